// ===== src/wgr_pkg.sv =====
// Shared types, constants and helper functions for the windowed glide ratio block.
// Has no dependencies; every other file of the block but wgr_ram imports it.
package wgr_pkg;

	localparam int RING_DEPTH = 256;
	localparam int RING_AW    = $clog2(RING_DEPTH);
	localparam int LEN_W      = RING_AW + 1;

	localparam int MODE_W    = 3;
	localparam int SDIST_W   = 16;
	localparam int DIST_W    = 8;
	localparam int ALT_W     = 16;
	localparam int TOTAL_W   = 15;
	localparam int DIVISOR_W = 16;
	localparam int RATIO_W   = 16;
	localparam int CNT_W     = $clog2(TOTAL_W + 1);

	localparam int DIST_MIN      = 3;
	localparam int DIST_MAX      = 150;
	localparam int RATIO_LIMIT   = 200;
	localparam int RATIO_INVALID = 999;

	// Mode register codes.
	localparam logic [MODE_W-1:0] MODE_LEN15  = 3'd0;
	localparam logic [MODE_W-1:0] MODE_LEN30  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_LEN60  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_LEN90  = 3'd3;
	localparam logic [MODE_W-1:0] MODE_LEN120 = 3'd4;
	localparam logic [MODE_W-1:0] MODE_LEN180 = 3'd5;

	typedef struct packed {
		logic        [SDIST_W-1:0] sample_distance;
		logic signed [ALT_W-1:0]   sample_altitude;
	} sample_t;

	typedef struct packed {
		logic signed [RATIO_W-1:0] glide_ratio;
		logic                      sample_accepted;
	} result_t;

	// One classified item as it waits between the front and the back.
	typedef struct packed {
		logic        [DIST_W-1:0] distance;
		logic signed [ALT_W-1:0]  altitude;
		logic                     accepted;
	} entry_t;

	// Window length in samples; the unused codes fall back to three samples.
	function automatic logic [LEN_W-1:0] window_len(input logic [MODE_W-1:0] mode);
		logic [LEN_W-1:0] len;
		unique case (mode)
			MODE_LEN15:  len = LEN_W'(15);
			MODE_LEN30:  len = LEN_W'(30);
			MODE_LEN60:  len = LEN_W'(60);
			MODE_LEN90:  len = LEN_W'(90);
			MODE_LEN120: len = LEN_W'(120);
			MODE_LEN180: len = LEN_W'(180);
			default:     len = LEN_W'(3);
		endcase
		return len;
	endfunction

endpackage

// ===== src/wgr_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module wgr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== src/wgr_div.sv =====
// Unsigned restoring divider, one quotient bit per cycle.
// Depends on wgr_pkg.
module wgr_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [wgr_pkg::TOTAL_W-1:0]     dividend,
	input  logic [wgr_pkg::DIVISOR_W-1:0]   divisor,
	output logic                            done,
	output logic [wgr_pkg::TOTAL_W-1:0]     quotient
);
	import wgr_pkg::*;

	logic                   busy_q;
	logic                   done_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [DIVISOR_W-1:0]   rem_q;
	logic [TOTAL_W-1:0]     quo_q;
	logic [DIVISOR_W-1:0]   div_q;
	logic [DIVISOR_W:0]     trial;
	logic                   fits;

	assign trial = {rem_q, quo_q[TOTAL_W-1]};
	assign fits  = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(TOTAL_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// The partial remainder stays below the divisor, so it fits the divisor width.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= DIVISOR_W'(fits ? trial - {1'b0, div_q} : trial);
			quo_q <= {quo_q[TOTAL_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== src/wgr_front.sv =====
// Front end: takes sample items and classifies the distance as accepted or not.
// Depends on wgr_pkg; feeds wgr_queue.
module wgr_front (
	input  logic              sample_valid,
	output logic              sample_stall,
	input  wgr_pkg::sample_t  sample,
	input  logic              queue_full,
	output logic              push,
	output wgr_pkg::entry_t   entry
);
	import wgr_pkg::*;

	logic in_range;

	assign in_range = (sample.sample_distance >= SDIST_W'(DIST_MIN))
		&& (sample.sample_distance <= SDIST_W'(DIST_MAX));

	assign sample_stall   = queue_full;
	assign push           = sample_valid && !queue_full;
	assign entry.distance = sample.sample_distance[DIST_W-1:0];
	assign entry.altitude = sample.sample_altitude;
	assign entry.accepted = in_range;

endmodule

// ===== src/wgr_queue.sv =====
// Two-entry queue between the front end and the back end.
// Depends on wgr_pkg.
module wgr_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  wgr_pkg::entry_t  push_entry,
	output logic             full,
	input  logic             pop,
	output logic             empty,
	output wgr_pkg::entry_t  head
);
	import wgr_pkg::*;

	entry_t      slot_q [2];
	logic        wr_q;
	logic        rd_q;
	logic [1:0]  count_q;

	assign full  = count_q == 2'd2;
	assign empty = count_q == 2'd0;
	assign head  = slot_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_entry;
		end
	end

endmodule

// ===== src/wgr_back.sv =====
// Back end: window bookkeeping, ring memories, divider and the result register.
// Depends on wgr_pkg, wgr_ram and wgr_div.
module wgr_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [wgr_pkg::MODE_W-1:0]    cfg_data,
	input  logic                          queue_empty,
	input  wgr_pkg::entry_t               head,
	output logic                          pop,
	output logic                          idle,
	output logic                          result_valid,
	input  logic                          result_stall,
	output wgr_pkg::result_t              result
);
	import wgr_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_RDIST = 3'd1;
	localparam logic [2:0] ST_EVAL  = 3'd2;
	localparam logic [2:0] ST_RALT  = 3'd3;
	localparam logic [2:0] ST_DIV   = 3'd4;
	localparam logic [2:0] ST_OUT   = 3'd5;

	logic [2:0]                st_q;
	entry_t                    item_q;
	logic [RING_AW-1:0]        pos_q;
	logic                      wrap_q;
	logic [MODE_W-1:0]         mode_q;
	logic [RING_AW-1:0]        newest_q;
	logic                      any_q;
	logic                      full_q;
	logic [TOTAL_W-1:0]        total_q;
	logic signed [ALT_W-1:0]   newest_alt_q;
	logic signed [RATIO_W-1:0] ratio_q;
	logic                      neg_q;

	logic [LEN_W-1:0]          len;
	logic [LEN_W-1:0]          next_idx;
	logic                      wrap_c;
	logic [RING_AW-1:0]        pos_c;
	logic [RING_AW-1:0]        oldest_c;
	logic                      no_ratio_c;
	logic                      full_new;
	logic [DIST_W-1:0]         dist_rdata;
	logic [ALT_W-1:0]          alt_rdata;
	logic signed [ALT_W:0]     fall;
	logic [DIVISOR_W-1:0]      fall_mag;
	logic                      div_start;
	logic                      div_done;
	logic [TOTAL_W-1:0]        div_quo;
	logic                      ring_we;

	assign len      = window_len(mode_q);
	assign next_idx = {1'b0, newest_q} + LEN_W'(1);
	assign wrap_c   = any_q && (next_idx >= len);
	assign pos_c    = (!any_q || wrap_c) ? '0 : next_idx[RING_AW-1:0];
	assign oldest_c = (full_q && next_idx < len) ? next_idx[RING_AW-1:0] : '0;
	assign no_ratio_c = !any_q || (!full_q && newest_q == '0);
	assign full_new = full_q || wrap_q;

	assign fall     = $signed({alt_rdata[ALT_W-1], alt_rdata})
		- $signed({newest_alt_q[ALT_W-1], newest_alt_q});
	// The magnitude of a 17-bit altitude difference is at most 65535.
	assign fall_mag = fall[ALT_W] ? DIVISOR_W'(-fall) : DIVISOR_W'(fall);

	assign ring_we   = st_q == ST_RDIST;
	assign div_start = (st_q == ST_RALT) && (fall != '0);
	assign pop       = (st_q == ST_IDLE) && !queue_empty;
	assign idle      = (st_q == ST_IDLE) && queue_empty;

	wgr_ram #(.WIDTH(DIST_W), .DEPTH(RING_DEPTH)) u_dist_ring (
		.clk   (clk),
		.we    (ring_we),
		.waddr (pos_q),
		.wdata (item_q.distance),
		.raddr (pos_c),
		.rdata (dist_rdata)
	);

	wgr_ram #(.WIDTH(ALT_W), .DEPTH(RING_DEPTH)) u_alt_ring (
		.clk   (clk),
		.we    (ring_we),
		.waddr (pos_q),
		.wdata (item_q.altitude),
		.raddr (oldest_c),
		.rdata (alt_rdata)
	);

	wgr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (total_q),
		.divisor  (fall_mag),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_IDLE;
			mode_q   <= MODE_LEN15;
			newest_q <= '0;
			any_q    <= 1'b0;
			full_q   <= 1'b0;
			total_q  <= '0;
		end else if (cfg_we) begin
			mode_q   <= cfg_data;
			newest_q <= '0;
			any_q    <= 1'b0;
			full_q   <= 1'b0;
			total_q  <= '0;
		end else begin
			unique case (st_q)
				ST_IDLE: begin
					if (!queue_empty) begin
						st_q <= head.accepted ? ST_RDIST : ST_EVAL;
					end
				end
				ST_RDIST: begin
					// The slot about to be overwritten leaves the running total.
					total_q  <= total_q - (full_new ? TOTAL_W'(dist_rdata) : '0)
						+ TOTAL_W'(item_q.distance);
					full_q   <= full_new;
					any_q    <= 1'b1;
					newest_q <= pos_q;
					st_q     <= ST_EVAL;
				end
				ST_EVAL: begin
					st_q <= no_ratio_c ? ST_OUT : ST_RALT;
				end
				ST_RALT: begin
					st_q <= (fall == '0) ? ST_OUT : ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						st_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!result_stall) begin
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			ST_IDLE: begin
				item_q <= head;
				pos_q  <= pos_c;
				wrap_q <= wrap_c;
			end
			ST_RDIST: begin
				newest_alt_q <= item_q.altitude;
			end
			ST_EVAL: begin
				ratio_q <= '0;
			end
			ST_RALT: begin
				ratio_q <= RATIO_W'(RATIO_INVALID);
				neg_q   <= fall[ALT_W];
			end
			ST_DIV: begin
				if (neg_q) begin
					ratio_q <= RATIO_W'(0) - RATIO_W'({1'b0, div_quo});
				end else if (div_quo > TOTAL_W'(RATIO_LIMIT)) begin
					ratio_q <= RATIO_W'(RATIO_INVALID);
				end else begin
					ratio_q <= RATIO_W'({1'b0, div_quo});
				end
			end
			default: begin
			end
		endcase
	end

	assign result_valid           = st_q == ST_OUT;
	assign result.glide_ratio     = ratio_q;
	assign result.sample_accepted = item_q.accepted;

	a_full_needs_any: assert property (@(posedge clk) disable iff (!arst_n)
		full_q |-> any_q)
		else $error("window marked full while empty");

	a_newest_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, newest_q} < len)
		else $error("newest slot lies outside the window");

	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(total_q) <= DIST_MAX * int'(len))
		else $error("distance total exceeds what the window can hold");

	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> st_q == ST_DIV)
		else $error("divider finished outside the divide step");

	a_cfg_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |-> st_q == ST_IDLE)
		else $error("mode written while an item is in flight");

endmodule

// ===== src/windowed_glide_ratio_top.sv =====
// Top level of the windowed glide ratio block.
// Depends on wgr_pkg, wgr_front, wgr_queue and wgr_back.
module windowed_glide_ratio_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         sample_valid,
	output logic                         sample_stall,
	input  wgr_pkg::sample_t             sample,
	output logic                         result_valid,
	input  logic                         result_stall,
	output wgr_pkg::result_t             result,
	input  logic                         mode_valid,
	output logic                         mode_ready,
	input  logic [wgr_pkg::MODE_W-1:0]   mode_data
);
	// Each sample item yields exactly one result item carrying the glide ratio of
	// the current window and a flag telling whether the distance (3 to 150) was
	// stored. An accepted sample goes from leaving the queue to its result
	// through these steps in order: one that pops it and reads the ring
	// slot about to be replaced, the update, a read of the oldest altitude,
	// one that forms the altitude fall and starts the bit-serial divider,
	// the divider (fifteen quotient steps and one that flags completion)
	// and the result. A rejected sample skips the update. An item whose
	// window yields no ratio skips forming the fall and the divider, and one
	// with no altitude change skips only the divider. The divider sets
	// the sustained rate. A two-entry queue sits between the input classifier and
	// the window logic, so up to two items are taken while one is still being
	// worked on, and the result register holds its item for as long as
	// result_stall is high. Writing the mode register selects the window length
	// and empties the window; mode_ready is high only when no item is queued or in
	// flight. The ring memories need no clearing after reset, since only slots
	// written since the window was last emptied are ever read.
	import wgr_pkg::*;

	logic   push;
	logic   pop;
	logic   queue_full;
	logic   queue_empty;
	logic   back_idle;
	entry_t push_entry;
	entry_t head;

	wgr_front u_front (
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.queue_full   (queue_full),
		.push         (push),
		.entry        (push_entry)
	);

	wgr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (queue_full),
		.pop        (pop),
		.empty      (queue_empty),
		.head       (head)
	);

	// Configuration is taken only when nothing is queued or being worked on.
	assign mode_ready = back_idle;

	wgr_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (mode_valid && mode_ready),
		.cfg_data     (mode_data),
		.queue_empty  (queue_empty),
		.head         (head),
		.pop          (pop),
		.idle         (back_idle),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule
